@@ rtl/dimsfx_pkg.sv @@
package dimsfx_pkg;

  localparam int unsigned ValueW = 31;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned DigitW = 4;

  localparam logic [PhaseW-1:0] PH_W_FIRST = 3'd0;
  localparam logic [PhaseW-1:0] PH_W_MORE  = 3'd1;
  localparam logic [PhaseW-1:0] PH_H_FIRST = 3'd2;
  localparam logic [PhaseW-1:0] PH_H_MORE  = 3'd3;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_X    = 8'h78;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       first_item;
    logic       last_item;
    logic       prev_is_space;
  } item_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ValueW-1:0] width_acc;
    logic [ValueW-1:0] height_acc;
    logic              failed;
  } state_t;

  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] width_value;
    logic              has_height;
    logic [ValueW-1:0] height_value;
  } result_t;

  localparam state_t STATE_CLEAR = '{
    phase:      PH_W_FIRST,
    width_acc:  '0,
    height_acc: '0,
    failed:     1'b0
  };

endpackage

@@ rtl/dimsfx_acc10.sv @@
module dimsfx_acc10 (
  input  logic [dimsfx_pkg::ValueW-1:0] acc,
  input  logic [dimsfx_pkg::DigitW-1:0] digit,
  output logic [dimsfx_pkg::ValueW-1:0] sum,
  output logic                          ovf
);

  localparam int unsigned ExtW = dimsfx_pkg::ValueW + 4;

  logic [ExtW-1:0] acc_ext;
  logic [ExtW-1:0] total;

  assign acc_ext = {4'b0, acc};
  // acc * 10 as two shifts, then the new digit
  assign total   = (acc_ext << 3) + (acc_ext << 1)
                 + {{(ExtW-dimsfx_pkg::DigitW){1'b0}}, digit};
  assign ovf     = |total[ExtW-1:dimsfx_pkg::ValueW];
  assign sum     = total[dimsfx_pkg::ValueW-1:0];

endmodule

@@ rtl/dimsfx_step.sv @@
module dimsfx_step (
  input  dimsfx_pkg::state_t  st,
  input  dimsfx_pkg::item_t   item,
  output dimsfx_pkg::state_t  st_nxt,
  output dimsfx_pkg::result_t res
);

  dimsfx_pkg::state_t                base;
  dimsfx_pkg::state_t                post;
  logic                              is_digit;
  logic                              is_lead;
  logic [dimsfx_pkg::DigitW-1:0]     digit;
  logic [dimsfx_pkg::ValueW-1:0]     acc_sel;
  logic [dimsfx_pkg::ValueW-1:0]     acc_sum;
  logic                              acc_ovf;
  logic                              ok;
  logic                              hh;

  assign is_digit = (item.text_byte >= dimsfx_pkg::CH_ZERO) &&
                    (item.text_byte <= dimsfx_pkg::CH_NINE);
  assign is_lead  = (item.text_byte >= dimsfx_pkg::CH_ONE) &&
                    (item.text_byte <= dimsfx_pkg::CH_NINE);
  assign digit    = item.text_byte[dimsfx_pkg::DigitW-1:0];

  always_comb begin
    base = st;
    if (item.first_item) begin
      base        = dimsfx_pkg::STATE_CLEAR;
      base.failed = item.prev_is_space;
    end
  end

  assign acc_sel = (base.phase == dimsfx_pkg::PH_W_MORE) ? base.width_acc : base.height_acc;

  dimsfx_acc10 u_acc10 (
    .acc   (acc_sel),
    .digit (digit),
    .sum   (acc_sum),
    .ovf   (acc_ovf)
  );

  always_comb begin
    post = base;
    if (item.has_byte && !base.failed) begin
      unique case (base.phase)
        dimsfx_pkg::PH_W_FIRST: begin
          if (is_lead) begin
            post.width_acc = {{(dimsfx_pkg::ValueW-dimsfx_pkg::DigitW){1'b0}}, digit};
            post.phase     = dimsfx_pkg::PH_W_MORE;
          end else begin
            post.failed = 1'b1;
          end
        end
        dimsfx_pkg::PH_W_MORE: begin
          if (is_digit) begin
            if (acc_ovf) post.failed = 1'b1;
            else         post.width_acc = acc_sum;
          end else if (item.text_byte == dimsfx_pkg::CH_X) begin
            post.phase = dimsfx_pkg::PH_H_FIRST;
          end else begin
            post.failed = 1'b1;
          end
        end
        dimsfx_pkg::PH_H_FIRST: begin
          if (is_lead) begin
            post.height_acc = {{(dimsfx_pkg::ValueW-dimsfx_pkg::DigitW){1'b0}}, digit};
            post.phase      = dimsfx_pkg::PH_H_MORE;
          end else begin
            post.failed = 1'b1;
          end
        end
        dimsfx_pkg::PH_H_MORE: begin
          if (is_digit && !acc_ovf) post.height_acc = acc_sum;
          else                      post.failed = 1'b1;
        end
        default: begin
          post.failed = 1'b1;
        end
      endcase
    end
  end

  assign ok = !post.failed &&
              ((post.phase == dimsfx_pkg::PH_W_MORE) || (post.phase == dimsfx_pkg::PH_H_MORE));
  assign hh = ok && (post.phase == dimsfx_pkg::PH_H_MORE);

  assign res.ok           = ok;
  assign res.width_value  = ok ? post.width_acc : '0;
  assign res.has_height   = hh;
  assign res.height_value = hh ? post.height_acc : '0;

  // a result closes the suffix
  assign st_nxt = item.last_item ? dimsfx_pkg::STATE_CLEAR : post;

endmodule

@@ rtl/dimension_suffix_parser.sv @@
// dimension_suffix_parser: parses an image-label size suffix, WIDTH or WIDTHxHEIGHT
//
// input channel: one suffix byte per request (in_valid / in_ready); in_first_item
//   restarts parsing, in_last_item closes the suffix and produces one result;
//   in_has_byte low carries no byte, so an empty suffix is a single such request
// result channel: out_valid / out_ready with out_ok, out_width_value,
//   out_has_height and out_height_value; values read zero when not ok
// result path: the last byte passes through the input register, then the result
//   register, which presents the result request
// throughput: one byte per cycle unless a last byte waits on a held result, set by
//   the combinational state update (times-ten add, overflow compare) between them
// stall: a waiting result holds its register; bytes that produce no result still
//   advance, and the next last byte waits in the input register until the result
//   is taken, with in_ready low meanwhile
// reset: rst_n synchronous active low; clears both valid flags and returns the
//   parser to expecting the first width digit
module dimension_suffix_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_has_byte,
  input  logic        in_first_item,
  input  logic        in_last_item,
  input  logic        in_prev_is_space,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [30:0] out_width_value,
  output logic        out_has_height,
  output logic [30:0] out_height_value
);

  logic                s1_valid_r;
  dimsfx_pkg::item_t   s1_item_r;
  logic                s1_go;
  dimsfx_pkg::state_t  st_r;
  dimsfx_pkg::state_t  st_nxt;
  dimsfx_pkg::result_t res_nxt;
  logic                out_valid_r;
  dimsfx_pkg::result_t out_r;

  assign s1_go    = s1_valid_r && (!s1_item_r.last_item || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.text_byte     <= in_text_byte;
      s1_item_r.has_byte      <= in_has_byte;
      s1_item_r.first_item    <= in_first_item;
      s1_item_r.last_item     <= in_last_item;
      s1_item_r.prev_is_space <= in_prev_is_space;
    end
  end

  dimsfx_step u_step (
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dimsfx_pkg::STATE_CLEAR;
    end else if (s1_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_item_r.last_item) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item_r.last_item) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_r.ok;
  assign out_width_value  = out_r.width_value;
  assign out_has_height   = out_r.has_height;
  assign out_height_value = out_r.height_value;

`ifndef ASSERT_OFF
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.ok |-> out_r.width_value == '0 && !out_r.has_height)
    else $error("failed result carries a width or height");

  a_height_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.has_height |-> out_r.ok)
    else $error("height flagged on a failed result");

  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_item_r.last_item |=> st_r.phase == dimsfx_pkg::PH_W_FIRST && !st_r.failed)
    else $error("parser state not cleared after a result");
`endif

endmodule

@@ tb/suffix_dims_checker.sv @@
`timescale 1ns / 100ps

module suffix_dims_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_has_byte,
  input  logic                          in_first_item,
  input  logic                          in_last_item,
  input  logic                          in_prev_is_space,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_ok,
  input  logic [dimsfx_pkg::ValueW-1:0] out_width_value,
  input  logic                          out_has_height,
  input  logic [dimsfx_pkg::ValueW-1:0] out_height_value,
  output int unsigned                   mismatches,
  output int unsigned                   outstanding
);

  localparam int unsigned ValueW   = dimsfx_pkg::ValueW;
  localparam int unsigned DigitW   = dimsfx_pkg::DigitW;
  localparam int unsigned MaxValue = 32'h7FFF_FFFF;

  dimsfx_pkg::state_t  sfx;
  dimsfx_pkg::result_t pending_dims[$];

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic bit digit_fits(logic [ValueW-1:0] acc, logic [DigitW-1:0] d);
    return 32'(acc) <= (MaxValue - 32'(d)) / 10;
  endfunction

  // next parser state for one accepted request, pushing the dimensions it closes
  task automatic parse_request(dimsfx_pkg::item_t it);
    logic [DigitW-1:0]   d;
    bit                  is_digit;
    bit                  is_lead;
    dimsfx_pkg::result_t dims;
    if (it.first_item) begin
      sfx = dimsfx_pkg::STATE_CLEAR;
      sfx.failed = it.prev_is_space;
    end
    if (it.has_byte && !sfx.failed) begin
      is_digit = it.text_byte >= dimsfx_pkg::CH_ZERO && it.text_byte <= dimsfx_pkg::CH_NINE;
      is_lead  = it.text_byte >= dimsfx_pkg::CH_ONE && it.text_byte <= dimsfx_pkg::CH_NINE;
      d = DigitW'(it.text_byte - dimsfx_pkg::CH_ZERO);
      case (sfx.phase)
        dimsfx_pkg::PH_W_FIRST: begin
          if (is_lead) begin
            sfx.width_acc = ValueW'(d);
            sfx.phase = dimsfx_pkg::PH_W_MORE;
          end else begin
            sfx.failed = 1'b1;
          end
        end
        dimsfx_pkg::PH_W_MORE: begin
          if (is_digit) begin
            if (digit_fits(sfx.width_acc, d)) begin
              sfx.width_acc = ValueW'(sfx.width_acc * 10 + d);
            end else begin
              sfx.failed = 1'b1;
            end
          end else if (it.text_byte == dimsfx_pkg::CH_X) begin
            sfx.phase = dimsfx_pkg::PH_H_FIRST;
          end else begin
            sfx.failed = 1'b1;
          end
        end
        dimsfx_pkg::PH_H_FIRST: begin
          if (is_lead) begin
            sfx.height_acc = ValueW'(d);
            sfx.phase = dimsfx_pkg::PH_H_MORE;
          end else begin
            sfx.failed = 1'b1;
          end
        end
        dimsfx_pkg::PH_H_MORE: begin
          if (is_digit && digit_fits(sfx.height_acc, d)) begin
            sfx.height_acc = ValueW'(sfx.height_acc * 10 + d);
          end else begin
            sfx.failed = 1'b1;
          end
        end
        default: sfx.failed = 1'b1;
      endcase
    end
    if (it.last_item) begin
      dims.ok           = !sfx.failed && (sfx.phase == dimsfx_pkg::PH_W_MORE ||
                                          sfx.phase == dimsfx_pkg::PH_H_MORE);
      dims.has_height   = dims.ok && sfx.phase == dimsfx_pkg::PH_H_MORE;
      dims.width_value  = dims.ok ? sfx.width_acc : '0;
      dims.height_value = dims.has_height ? sfx.height_acc : '0;
      pending_dims.push_back(dims);
      sfx = dimsfx_pkg::STATE_CLEAR;
    end
  endtask

  always @(posedge clk) begin
    dimsfx_pkg::result_t want;
    if (!rst_n) begin
      sfx = dimsfx_pkg::STATE_CLEAR;
      pending_dims.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_dims.size() == 0) begin
          report_mismatch("result with no suffix pending, width", out_width_value, -1);
        end else begin
          want = pending_dims.pop_front();
          if (out_ok !== want.ok)
            report_mismatch("ok", out_ok, want.ok);
          if (out_width_value !== want.width_value)
            report_mismatch("width_value", out_width_value, want.width_value);
          if (out_has_height !== want.has_height)
            report_mismatch("has_height", out_has_height, want.has_height);
          if (out_height_value !== want.height_value)
            report_mismatch("height_value", out_height_value, want.height_value);
        end
      end
      if (in_valid && in_ready) begin
        parse_request('{text_byte: in_text_byte, has_byte: in_has_byte,
                        first_item: in_first_item, last_item: in_last_item,
                        prev_is_space: in_prev_is_space});
      end
    end
    outstanding = pending_dims.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RequestTarget = 1650;
  localparam int unsigned CycleLimit    = 1_000_000;

  typedef logic [8:0] slot_q_t[$];

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_text_byte;
  logic                          in_has_byte;
  logic                          in_first_item;
  logic                          in_last_item;
  logic                          in_prev_is_space;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_ok;
  logic [dimsfx_pkg::ValueW-1:0] out_width_value;
  logic                          out_has_height;
  logic [dimsfx_pkg::ValueW-1:0] out_height_value;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned requests_sent;
  int unsigned cycles;

  dimension_suffix_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_has_byte      (in_has_byte),
    .in_first_item    (in_first_item),
    .in_last_item     (in_last_item),
    .in_prev_is_space (in_prev_is_space),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_width_value  (out_width_value),
    .out_has_height   (out_has_height),
    .out_height_value (out_height_value)
  );

  suffix_dims_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_has_byte      (in_has_byte),
    .in_first_item    (in_first_item),
    .in_last_item     (in_last_item),
    .in_prev_is_space (in_prev_is_space),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_width_value  (out_width_value),
    .out_has_height   (out_has_height),
    .out_height_value (out_height_value),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // bit 8 of a slot is has_byte
  function automatic slot_q_t text_slots(string s);
    slot_q_t q;
    if (s.len() == 0) q.push_back({1'b0, 8'($urandom)});
    for (int i = 0; i < s.len(); i++) q.push_back({1'b1, s[i]});
    return q;
  endfunction

  function automatic longint unsigned pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(1, 999);
      5, 6:          return $urandom_range(1, 32'h7FFF_FFFF);
      7, 8:          return 64'd2147483642 + $urandom_range(0, 10);
      default:       return {$urandom, $urandom} % 64'd99_999_999_999 + 1;
    endcase
  endfunction

  task automatic send_request(logic [8:0] slot, bit first, bit last, bit prev_space);
    in_valid         <= 1'b1;
    in_text_byte     <= slot[7:0];
    in_has_byte      <= slot[8];
    in_first_item    <= first;
    in_last_item     <= last;
    in_prev_is_space <= prev_space;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (slot[8] || last) requests_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    repeat (($urandom_range(0, 11) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3))
      @(posedge clk);
  endtask

  task automatic send_suffix(slot_q_t q, bit prev_space, bit mark_first, bit no_gaps);
    bit first;
    bit last;
    for (int i = 0; i < q.size(); i++) begin
      first = (i == 0) ? mark_first : ($urandom_range(0, 49) == 0);
      last  = (i == q.size() - 1);
      send_request(q[i], first, last, (i == 0) ? prev_space : 1'($urandom));
      if (!no_gaps && $urandom_range(0, 3) == 0) idle_input();
    end
  endtask

  function automatic slot_q_t random_suffix();
    slot_q_t q;
    int      pos;
    int      len;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 1) == 1)
        q = text_slots($sformatf("%0dx%0d", pick_value(), pick_value()));
      else
        q = text_slots($sformatf("%0d", pick_value()));
      // occasional damage to a well-formed suffix
      if ($urandom_range(0, 9) == 0) begin
        pos = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 4))
          0: q[pos] = {1'b1, 8'($urandom)};
          1: q.push_front({1'b1, dimsfx_pkg::CH_ZERO});
          2: q.push_back({1'b1, dimsfx_pkg::CH_X});
          3: q.insert(pos, {1'b1, dimsfx_pkg::CH_X});
          default: if (q.size() > 1) q.delete(pos);
        endcase
      end
    end else begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        if ($urandom_range(0, 1) == 1)
          q.push_back({($urandom_range(0, 4) != 0), 8'($urandom)});
        else if ($urandom_range(0, 10) == 0)
          q.push_back({($urandom_range(0, 4) != 0), dimsfx_pkg::CH_X});
        else
          q.push_back({($urandom_range(0, 4) != 0),
                       8'(dimsfx_pkg::CH_ZERO + $urandom_range(0, 9))});
      end
    end
    if ($urandom_range(0, 14) == 0)
      q.insert($urandom_range(0, q.size() - 1), {1'b0, 8'($urandom)});
    if ($urandom_range(0, 9) == 0)
      q.push_back({1'b0, 8'($urandom)});
    return q;
  endfunction

  initial begin : result_sink
    int unsigned elapsed;
    int unsigned span;
    bit          held_off;
    elapsed  = 0;
    held_off = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held_off && elapsed >= 1000) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        span = 400;
      end else if ($urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        span = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
      end else begin
        out_ready <= 1'b0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      end
      repeat (span) @(posedge clk);
      elapsed += span;
    end
  end

  initial begin : stimulus
    bit drained;
    drained          = 1'b0;
    requests_sent    = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_text_byte     <= '0;
    in_has_byte      <= 1'b0;
    in_first_item    <= 1'b0;
    in_last_item     <= 1'b0;
    in_prev_is_space <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_suffix(text_slots(""), 1'b0, 1'b1, 1'b1);
    send_suffix(text_slots("7"), 1'b1, 1'b1, 1'b1);
    send_suffix(text_slots("0"), 1'b0, 1'b1, 1'b0);
    send_suffix(text_slots("1x"), 1'b0, 1'b1, 1'b1);
    send_suffix(text_slots("10x20"), 1'b0, 1'b0, 1'b1);
    send_suffix(text_slots("2147483647"), 1'b0, 1'b1, 1'b0);
    send_suffix(text_slots("3xx"), 1'b0, 1'b1, 1'b1);

    while (requests_sent < RequestTarget) begin
      if (!drained && requests_sent >= 800) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        @(posedge clk);
      end
      send_suffix(random_suffix(), ($urandom_range(0, 12) == 0),
                  ($urandom_range(0, 6) != 0), ($urandom_range(0, 4) < 2));
      if ($urandom_range(0, 2) == 0) idle_input();
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
